// ===== rtl/core/kcr_pkg.sv =====
// Package of the keyframe color ramp: widths, limits and shared codes.
// No dependencies; every other file of the block imports it.
package kcr_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CH_W = 8;
	localparam int NUM_CH = 4;
	localparam int COLOR_W = CH_W * NUM_CH;
	localparam int TICK_W = 16;
	localparam int TIME_W = 32;
	localparam int TOTAL_W = TICK_W + IDX_W;
	localparam int MASK_W = 8;
	localparam int ENTRY_COUNT_W = 5;
	localparam int DELAY_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [COLOR_W-1:0] HELD_RESET = '1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} req_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEWER_MASK = 2'd0,
		CFG_HIDDEN_TEAMS = 2'd1,
		CFG_ENTRY_COUNT = 2'd2,
		CFG_START_DELAY = 2'd3
	} cfg_reg_t;

endpackage

// ===== rtl/core/kcr_if.sv =====
// Valid/ready channels of the keyframe color ramp: request and result.
// Depends on kcr_pkg for field widths and the operation code.
interface kcr_req_if;
	import kcr_pkg::*;

	logic valid;
	logic ready;
	req_op_t op;
	logic [IDX_W-1:0] entry_index;
	logic [CH_W-1:0] key_red;
	logic [CH_W-1:0] key_green;
	logic [CH_W-1:0] key_blue;
	logic [CH_W-1:0] key_alpha;
	logic [TICK_W-1:0] key_duration;
	logic [TIME_W-1:0] time_now;

	modport source (
		output valid, op, entry_index, key_red, key_green, key_blue, key_alpha,
		output key_duration, time_now,
		input ready
	);
	modport sink (
		input valid, op, entry_index, key_red, key_green, key_blue, key_alpha,
		input key_duration, time_now,
		output ready
	);
endinterface

interface kcr_rsp_if;
	import kcr_pkg::*;

	logic valid;
	logic ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic [CH_W-1:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input ready
	);
	modport sink (
		input valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

// ===== rtl/core/keyframe_color_ramp.sv =====
// Keyframe color ramp top level: microcoded sequencer, keyframe tables and datapath.
// Depends on kcr_pkg and the kcr_req_if / kcr_rsp_if channels.
//
// A load request writes one keyframe entry as it is accepted and gives no result. An
// evaluate request runs a short microprogram and gives one RGBA result. Most of its
// length lies in the 33-step restoring modulo that forms the phase, the two passes over
// the duration table through its single read port, and the 8-step divide of the blend,
// done for all four channels at once. Hidden and empty cases skip all of these, and a
// single entry or a zero total skips all but the summing pass. The block takes one request
// at a time; a finished result waits in the output register while the next request is
// accepted, and a new result waits for that register to empty.
module keyframe_color_ramp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [kcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [kcr_pkg::CFG_DATA_W-1:0] cfg_data,
	kcr_req_if.sink req,
	kcr_rsp_if.source rsp
);
	import kcr_pkg::*;

	localparam int DVD_W = TIME_W + 1;
	localparam int STEP_W = $clog2(DVD_W);
	localparam int V_W = TICK_W + CH_W;
	localparam logic [STEP_W-1:0] DIVP_LAST = STEP_W'(DVD_W - 1);
	localparam logic [STEP_W-1:0] BLEND_LAST = STEP_W'(CH_W - 1);

	typedef enum logic [4:0] {
		S_WAIT = 5'd0,
		S_HIDE_T = 5'd1,
		S_EMPTY_T = 5'd2,
		S_SUM = 5'd3,
		S_ONE_T = 5'd4,
		S_DIVP = 5'd5,
		S_SCAN0 = 5'd6,
		S_SCAN = 5'd7,
		S_RDP = 5'd8,
		S_RDN = 5'd9,
		S_LATN = 5'd10,
		S_MUL = 5'd11,
		S_DIVB = 5'd12,
		S_BLEND = 5'd13,
		S_USEN = 5'd14,
		S_FIRST = 5'd15,
		S_FIRST2 = 5'd16,
		S_HIDE = 5'd17,
		S_EMIT = 5'd18,
		S_HOLD = 5'd19
	} step_t;

	typedef enum logic [3:0] {
		U_NOP,
		U_SUM_INIT,
		U_SUM,
		U_DIV_INIT,
		U_DIV_STEP,
		U_SCAN_INIT,
		U_SCAN,
		U_RD_PREV,
		U_RD_NEXT,
		U_LAT_NEXT,
		U_MUL,
		U_BLEND_STEP,
		U_SET_BLEND,
		U_SET_NEXT,
		U_SET_READ,
		U_HIDE
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_START,
		C_HIDDEN,
		C_EMPTY,
		C_SUM_MORE,
		C_SINGLE,
		C_DIVP_MORE,
		C_SCAN_MORE,
		C_ZERO_DUR,
		C_BLEND_MORE,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		uop_t op;
		cond_t cond;
		step_t target;
	} ucw_t;

	// Control store: one word per step, a taken condition jumps, otherwise the next step.
	function automatic ucw_t ucode(input step_t s);
		ucw_t w;
		case (s)
			S_WAIT: w = '{U_NOP, C_NOT_START, S_WAIT};
			S_HIDE_T: w = '{U_NOP, C_HIDDEN, S_HIDE};
			S_EMPTY_T: w = '{U_SUM_INIT, C_EMPTY, S_EMIT};
			S_SUM: w = '{U_SUM, C_SUM_MORE, S_SUM};
			S_ONE_T: w = '{U_DIV_INIT, C_SINGLE, S_FIRST};
			S_DIVP: w = '{U_DIV_STEP, C_DIVP_MORE, S_DIVP};
			S_SCAN0: w = '{U_SCAN_INIT, C_NEVER, S_WAIT};
			S_SCAN: w = '{U_SCAN, C_SCAN_MORE, S_SCAN};
			S_RDP: w = '{U_RD_PREV, C_NEVER, S_WAIT};
			S_RDN: w = '{U_RD_NEXT, C_NEVER, S_WAIT};
			S_LATN: w = '{U_LAT_NEXT, C_ZERO_DUR, S_USEN};
			S_MUL: w = '{U_MUL, C_NEVER, S_WAIT};
			S_DIVB: w = '{U_BLEND_STEP, C_BLEND_MORE, S_DIVB};
			S_BLEND: w = '{U_SET_BLEND, C_ALWAYS, S_EMIT};
			S_USEN: w = '{U_SET_NEXT, C_ALWAYS, S_EMIT};
			S_FIRST: w = '{U_NOP, C_NEVER, S_WAIT};
			S_FIRST2: w = '{U_SET_READ, C_ALWAYS, S_EMIT};
			S_HIDE: w = '{U_HIDE, C_NEVER, S_WAIT};
			S_EMIT: w = '{U_NOP, C_OUT_FREE, S_WAIT};
			S_HOLD: w = '{U_NOP, C_ALWAYS, S_EMIT};
			default: w = '{U_NOP, C_ALWAYS, S_WAIT};
		endcase
		return w;
	endfunction

	logic [COLOR_W-1:0] colors_mem [MAX_ENTRIES];
	logic [TICK_W-1:0] ticks_mem [MAX_ENTRIES];

	step_t pc_q;
	logic out_valid_q;
	logic [MASK_W-1:0] viewer_mask_q;
	logic [MASK_W-1:0] hidden_teams_q;
	logic [ENTRY_COUNT_W-1:0] entry_count_q;
	logic [DELAY_W-1:0] start_delay_q;
	logic [COLOR_W-1:0] held_color_q;

	logic [TIME_W-1:0] time_q;
	logic [COLOR_W-1:0] color_rd_q;
	logic [TICK_W-1:0] tick_rd_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] prev_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] cum_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [STEP_W-1:0] cnt_q;
	logic [TICK_W-1:0] dur_q;
	logic [TICK_W-1:0] left_q;
	logic [COLOR_W-1:0] prev_color_q;
	logic [COLOR_W-1:0] next_color_q;
	logic [TICK_W-1:0] brem_q [NUM_CH];
	logic [CH_W-1:0] bq_q [NUM_CH];
	logic [COLOR_W-1:0] out_color_q;

	ucw_t uw;
	logic req_acc;
	logic eval_acc;
	logic load_acc;
	logic out_free;
	logic cond_true;
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] idx_nxt;
	logic [CNT_W-1:0] prev_nxt;
	logic [IDX_W-1:0] next_idx;
	logic [IDX_W-1:0] tick_addr;
	logic [IDX_W-1:0] color_addr;
	logic [TOTAL_W:0] trial;
	logic trial_ge;
	logic [TOTAL_W-1:0] cum_nxt;
	logic found;
	logic [V_W-1:0] v [NUM_CH];
	logic [TICK_W:0] btrial [NUM_CH];
	logic bge [NUM_CH];

	assign uw = ucode(pc_q);
	assign req.ready = (pc_q == S_WAIT);
	assign req_acc = req.valid && req.ready;
	assign eval_acc = req_acc && (req.op == OP_EVAL);
	assign load_acc = req_acc && (req.op == OP_LOAD);
	assign out_free = !out_valid_q || rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.out_red = out_color_q[3*CH_W +: CH_W];
	assign rsp.out_green = out_color_q[2*CH_W +: CH_W];
	assign rsp.out_blue = out_color_q[CH_W +: CH_W];
	assign rsp.out_alpha = out_color_q[0 +: CH_W];

	always_comb begin
		if (int'(entry_count_q) > MAX_ENTRIES) begin
			n_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			n_eff = CNT_W'(entry_count_q);
		end
		idx_nxt = CNT_W'(idx_q) + CNT_W'(1);
		prev_nxt = CNT_W'(prev_q) + CNT_W'(1);
		next_idx = (prev_nxt < n_eff) ? prev_nxt[IDX_W-1:0] : '0;

		trial = {rem_q, dvd_q[DVD_W-1]};
		trial_ge = trial >= {1'b0, total_q};
		cum_nxt = cum_q + TOTAL_W'(tick_rd_q);
		found = cum_nxt >= rem_q;

		for (int c = 0; c < NUM_CH; c++) begin
			v[c] = V_W'(left_q) * V_W'(prev_color_q[c*CH_W +: CH_W])
				+ V_W'(dur_q - left_q) * V_W'(next_color_q[c*CH_W +: CH_W]);
			btrial[c] = {brem_q[c], bq_q[c][CH_W-1]};
			bge[c] = btrial[c] >= {1'b0, dur_q};
		end

		case (uw.op)
			U_SUM_INIT, U_SCAN_INIT: tick_addr = '0;
			default: tick_addr = idx_nxt[IDX_W-1:0];
		endcase
		case (uw.op)
			U_RD_PREV: color_addr = prev_q;
			U_RD_NEXT: color_addr = next_idx;
			default: color_addr = '0;
		endcase

		case (uw.cond)
			C_NEVER: cond_true = 1'b0;
			C_ALWAYS: cond_true = 1'b1;
			C_NOT_START: cond_true = !eval_acc;
			C_HIDDEN: cond_true = (viewer_mask_q & hidden_teams_q) != '0;
			C_EMPTY: cond_true = (n_eff == '0);
			C_SUM_MORE: cond_true = idx_nxt < n_eff;
			C_SINGLE: cond_true = (n_eff == CNT_W'(1)) || (total_q == '0);
			C_DIVP_MORE: cond_true = cnt_q != DIVP_LAST;
			C_SCAN_MORE: cond_true = !found && (idx_nxt < n_eff);
			C_ZERO_DUR: cond_true = (dur_q == '0);
			C_BLEND_MORE: cond_true = cnt_q != BLEND_LAST;
			C_OUT_FREE: cond_true = out_free;
			default: cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			colors_mem[req.entry_index] <= {req.key_red, req.key_green,
				req.key_blue, req.key_alpha};
			ticks_mem[req.entry_index] <= req.key_duration;
		end
		color_rd_q <= colors_mem[color_addr];
		tick_rd_q <= ticks_mem[tick_addr];
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			time_q <= req.time_now;
		end
		if ((pc_q == S_EMIT) && out_free) begin
			out_color_q <= held_color_q;
		end
		case (uw.op)
			U_SUM_INIT: begin
				total_q <= '0;
				idx_q <= '0;
			end
			U_SUM: begin
				total_q <= total_q + TOTAL_W'(tick_rd_q);
				idx_q <= idx_nxt[IDX_W-1:0];
			end
			U_DIV_INIT: begin
				rem_q <= '0;
				dvd_q <= DVD_W'(time_q) + DVD_W'(start_delay_q);
				cnt_q <= '0;
			end
			U_DIV_STEP: begin
				rem_q <= trial_ge ? TOTAL_W'(trial - {1'b0, total_q}) : trial[TOTAL_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q + STEP_W'(1);
			end
			U_SCAN_INIT: begin
				cum_q <= '0;
				idx_q <= '0;
			end
			U_SCAN: begin
				if (found || !(idx_nxt < n_eff)) begin
					prev_q <= idx_q;
					dur_q <= tick_rd_q;
					left_q <= TICK_W'(cum_nxt - rem_q);
				end else begin
					cum_q <= cum_nxt;
					idx_q <= idx_nxt[IDX_W-1:0];
				end
			end
			U_RD_NEXT: begin
				prev_color_q <= color_rd_q;
			end
			U_LAT_NEXT: begin
				next_color_q <= color_rd_q;
			end
			U_MUL: begin
				for (int c = 0; c < NUM_CH; c++) begin
					brem_q[c] <= v[c][V_W-1:CH_W];
					bq_q[c] <= v[c][CH_W-1:0];
				end
				cnt_q <= '0;
			end
			U_BLEND_STEP: begin
				for (int c = 0; c < NUM_CH; c++) begin
					brem_q[c] <= bge[c] ? TICK_W'(btrial[c] - {1'b0, dur_q})
						: btrial[c][TICK_W-1:0];
					bq_q[c] <= {bq_q[c][CH_W-2:0], bge[c]};
				end
				cnt_q <= cnt_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
			out_valid_q <= 1'b0;
			viewer_mask_q <= '0;
			hidden_teams_q <= '0;
			entry_count_q <= '0;
			start_delay_q <= '0;
			held_color_q <= HELD_RESET;
		end else begin
			pc_q <= cond_true ? uw.target : step_t'(pc_q + 5'd1);

			if ((pc_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (uw.op)
				U_SET_BLEND: held_color_q <= {bq_q[3], bq_q[2], bq_q[1], bq_q[0]};
				U_SET_NEXT: held_color_q <= next_color_q;
				U_SET_READ: held_color_q <= color_rd_q;
				U_HIDE: held_color_q[CH_W-1:0] <= '0;
				default: begin
				end
			endcase

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_VIEWER_MASK: viewer_mask_q <= cfg_data[MASK_W-1:0];
					CFG_HIDDEN_TEAMS: hidden_teams_q <= cfg_data[MASK_W-1:0];
					CFG_ENTRY_COUNT: entry_count_q <= cfg_data[ENTRY_COUNT_W-1:0];
					CFG_START_DELAY: start_delay_q <= cfg_data[DELAY_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	a_phase_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_SCAN0) |-> (rem_q < total_q))
		else $error("Phase is not below the total duration after the modulo.");

	a_left_within_dur: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_MUL) |-> (left_q <= dur_q))
		else $error("Remaining ticks exceed the duration of the found entry.");

	a_blend_rem_below_dur: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_DIVB) |-> ((brem_q[0] < dur_q) && (brem_q[NUM_CH-1] < dur_q)))
		else $error("Blend divider remainder is not below the divisor.");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.op == OP_EVAL)) |=> (pc_q == S_HIDE_T))
		else $error("An accepted evaluate request did not start the program.");

	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		((pc_q == S_EMIT) && out_free) |=> ((pc_q == S_WAIT) && rsp.valid))
		else $error("A written result did not return the sequencer to idle.");
`endif

endmodule
